@@ rtl/vsa_pkg.sv @@
// shared types, constants and codes of the vlsm subnet allocator
package vsa_pkg;

   localparam int DEFAULT_MAX_REQUESTS = 32;

   localparam int ADDR_W  = 32;
   localparam int TAG_W   = 16;
   localparam int COUNT_W = 31;
   localparam int EXP_W   = 5;
   localparam int PFX_W   = 6;
   localparam int CSR_IDX_W = 2;

   // status codes
   localparam logic [1:0] ST_OK            = 2'd0;
   localparam logic [1:0] ST_INVALID_COUNT = 2'd1;
   localparam logic [1:0] ST_NO_SPACE      = 2'd2;
   localparam logic [1:0] ST_TOO_MANY      = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDRESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_PREFIX  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORDER_DOWN   = 2'd2;

   // register reset values
   localparam logic [ADDR_W-1:0] BASE_ADDRESS_RESET = '0;
   localparam logic [PFX_W-1:0]  BASE_PREFIX_RESET  = 6'd24;
   localparam logic              ORDER_DOWN_RESET   = 1'b0;

   typedef struct packed {
      logic [TAG_W-1:0]   request_tag;
      logic [COUNT_W-1:0] host_count;
      logic               last_request;
   } req_item_type;

   typedef struct packed {
      logic [TAG_W-1:0]  result_tag;
      logic [ADDR_W-1:0] block_size;
      logic [ADDR_W-1:0] start_address;
      logic [PFX_W-1:0]  subnet_prefix;
      logic [1:0]        status;
      logic              last_result;
   } rsp_item_type;

   // one table entry: tag and size exponent
   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [EXP_W-1:0] exp;
   } entry_type;

   // base network as seen by the sequencer
   typedef struct packed {
      logic [ADDR_W-1:0] network;
      logic [ADDR_W:0]   total;
      logic              order_down;
   } base_cfg_type;

endpackage

@@ rtl/vlsm_subnet_allocator_top.sv @@
// top level of the vlsm subnet allocator
//
// Takes subnet requests one at a time (tag and host count); each count is
// rounded up to a power of two and inserted into a request table kept sorted
// by block size, largest first, equal sizes in arrival order. The request
// marked last closes the run: the summed sizes are checked against the base
// network, then one allocation per request is issued, packed upward from the
// network address or downward from the network end. A zero count, a full
// table or too little space yields a single error item instead, with status
// set and last_result high. Timing: a request is taken when start is high and
// busy is low. A stored request keeps the block busy through a prepare step,
// one shift step per held entry it moves past, one more compare step when
// the walk stops at an entry of equal or larger size, a place step and the
// space check, since the insertion walks the table one entry a cycle through
// the single read port of the table memory. A request that is not stored
// (zero count, full table, or an error already held) keeps it busy through
// the prepare step and the space check. On a last request without error,
// the allocations follow one per cycle, back to back, the first one after the
// space check via the emit state and the output register. Each item sits on
// rsp_data for exactly one cycle with rsp_strobe high and cannot be held off,
// so the receiver must take every item as it comes. busy drops on the cycle
// the final item of the run is presented. Configuration writes are always
// taken (csr_ready is tied high) and must only be made while busy is low.
module vlsm_subnet_allocator_top import vsa_pkg::*; #(
   parameter int MAX_REQUESTS = DEFAULT_MAX_REQUESTS
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 start,
   output logic                 busy,
   input  req_item_type         req_data,
   // result channel
   output logic                 rsp_strobe,
   output rsp_item_type         rsp_data,
   // configuration write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_data
);

   localparam int IDX_W = $clog2(MAX_REQUESTS);

   base_cfg_type     base_cfg;
   logic             tbl_wr_en;
   logic [IDX_W-1:0] tbl_wr_addr;
   entry_type        tbl_wr_data;
   logic [IDX_W-1:0] tbl_rd_addr;
   entry_type        tbl_rd_data;

   // registers and base network decode (mask, block total)
   vsa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .base_cfg  (base_cfg)
   );

   // sorted request table, read data in the cycle after the address
   vsa_table #(
      .DEPTH (MAX_REQUESTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   // insertion walk, space check and result walk; a shift writes the slot
   // above the one being read, so a shift never writes the entry it reads
   vsa_seq #(
      .MAX_REQUESTS (MAX_REQUESTS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .base_cfg   (base_cfg),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .wr_en      (tbl_wr_en),
      .wr_addr    (tbl_wr_addr),
      .wr_data    (tbl_wr_data),
      .rd_addr    (tbl_rd_addr),
      .rd_data    (tbl_rd_data)
   );

   // an accepted request keeps the block busy on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   // results come only out of work in progress
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without a request in progress");

   // an error item is single, closes the run and carries no block
   a_error_item: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status != ST_OK |->
         rsp_data.last_result && rsp_data.block_size == '0)
      else $error("malformed error item");

   // allocations have a power of two size
   a_pow2_size: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status == ST_OK && rsp_data.block_size != '0 |->
         $onehot(rsp_data.block_size))
      else $error("block size not a power of two");

   // a run's allocations follow back to back until the last one
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last_result |=> rsp_strobe)
      else $error("gap inside a result burst");

endmodule

@@ rtl/vsa_table.sv @@
// request table memory, one write port and one registered read port
module vsa_table import vsa_pkg::*; #(
   parameter int DEPTH = DEFAULT_MAX_REQUESTS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  entry_type                wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output entry_type                rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/vsa_csr.sv @@
// configuration registers and base network decode
module vsa_csr import vsa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_data,
   output base_cfg_type         base_cfg
);

   logic [ADDR_W-1:0] base_address_ff, base_address_in;
   logic [PFX_W-1:0]  base_prefix_ff, base_prefix_in;
   logic              order_down_ff, order_down_in;
   logic [PFX_W-1:0]  pfx;
   logic [PFX_W-1:0]  host_bits;
   logic [ADDR_W-1:0] mask;

   assign csr_ready = 1'b1;

   always_comb begin
      base_address_in = base_address_ff;
      base_prefix_in  = base_prefix_ff;
      order_down_in   = order_down_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BASE_ADDRESS: base_address_in = csr_data;
            CSR_BASE_PREFIX:  base_prefix_in  = csr_data[PFX_W-1:0];
            CSR_ORDER_DOWN:   order_down_in   = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_address_ff <= BASE_ADDRESS_RESET;
         base_prefix_ff  <= BASE_PREFIX_RESET;
         order_down_ff   <= ORDER_DOWN_RESET;
      end else begin
         base_address_ff <= base_address_in;
         base_prefix_ff  <= base_prefix_in;
         order_down_ff   <= order_down_in;
      end
   end

   // prefix above 32 acts as 32
   always_comb begin
      pfx = (base_prefix_ff > PFX_W'(ADDR_W)) ? PFX_W'(ADDR_W) : base_prefix_ff;
      host_bits = PFX_W'(ADDR_W) - pfx;
      mask = (pfx == '0) ? '0 : ({ADDR_W{1'b1}} << host_bits);
      base_cfg.network    = base_address_ff & mask;
      base_cfg.total      = (ADDR_W+1)'(1) << host_bits;
      base_cfg.order_down = order_down_ff;
   end

endmodule

@@ rtl/vsa_seq.sv @@
// sequencer: sorted insertion into the table, space check and result walk
module vsa_seq import vsa_pkg::*; #(
   parameter int MAX_REQUESTS = DEFAULT_MAX_REQUESTS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  req_item_type                    req_data,
   input  base_cfg_type                    base_cfg,
   output logic                            rsp_strobe,
   output rsp_item_type                    rsp_data,
   output logic                            wr_en,
   output logic [$clog2(MAX_REQUESTS)-1:0] wr_addr,
   output entry_type                       wr_data,
   output logic [$clog2(MAX_REQUESTS)-1:0] rd_addr,
   input  entry_type                       rd_data
);

   localparam int IDX_W = $clog2(MAX_REQUESTS);
   localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
   localparam int SUM_W = ADDR_W + CNT_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PREP  = 3'd1;
   localparam logic [2:0] S_SHIFT = 3'd2;
   localparam logic [2:0] S_PLACE = 3'd3;
   localparam logic [2:0] S_CHECK = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [TAG_W-1:0]   tag_ff, tag_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               last_ff, last_in;
   logic [EXP_W-1:0]   exp_ff, exp_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic [IDX_W-1:0]   k_ff, k_in;
   logic [CNT_W-1:0]   entry_count_ff, entry_count_in;
   logic [SUM_W-1:0]   size_sum_ff, size_sum_in;
   logic [1:0]         error_code_ff, error_code_in;
   logic [ADDR_W:0]    cur_ff, cur_in;
   rsp_item_type       rsp_ff, rsp_in;
   logic               rsp_strobe_ff, rsp_strobe_in;

   logic [EXP_W-1:0]   new_exp;
   logic [1:0]         err_final;
   logic [ADDR_W:0]    step_size;
   logic [ADDR_W:0]    cur_next;

   // exponent of the smallest power of two not below n, by halving search
   function automatic logic [EXP_W-1:0] ceil_log2(input logic [COUNT_W-1:0] n);
      logic [COUNT_W-1:0] v;
      logic [EXP_W-1:0]   e;
      v = n - COUNT_W'(1);
      e = '0;
      if (n > COUNT_W'(1)) begin
         if (v[30:16] != '0) begin e = e + EXP_W'(16); v = v >> 16; end
         if (v[15:8]  != '0) begin e = e + EXP_W'(8);  v = v >> 8;  end
         if (v[7:4]   != '0) begin e = e + EXP_W'(4);  v = v >> 4;  end
         if (v[3:2]   != '0) begin e = e + EXP_W'(2);  v = v >> 2;  end
         if (v[1]) begin e = e + EXP_W'(1); end
         e = e + EXP_W'(1);
      end
      return e;
   endfunction

   assign new_exp   = ceil_log2(count_ff);
   assign step_size = (ADDR_W+1)'(1) << rd_data.exp;
   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      state_in       = state_ff;
      tag_in         = tag_ff;
      count_in       = count_ff;
      last_in        = last_ff;
      exp_in         = exp_ff;
      pos_in         = pos_ff;
      k_in           = k_ff;
      entry_count_in = entry_count_ff;
      size_sum_in    = size_sum_ff;
      error_code_in  = error_code_ff;
      cur_in         = cur_ff;
      rsp_in         = rsp_ff;
      rsp_strobe_in  = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = pos_ff;
      wr_data        = rd_data;
      rd_addr        = '0;
      err_final      = error_code_ff;
      cur_next       = cur_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               tag_in   = req_data.request_tag;
               count_in = req_data.host_count;
               last_in  = req_data.last_request;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            exp_in = new_exp;
            priority if (count_ff == '0) begin
               if (error_code_ff == ST_OK) error_code_in = ST_INVALID_COUNT;
               state_in = S_CHECK;
            end else if (entry_count_ff >= CNT_W'(MAX_REQUESTS)) begin
               if (error_code_ff == ST_OK) error_code_in = ST_TOO_MANY;
               state_in = S_CHECK;
            end else if (error_code_ff != ST_OK) begin
               state_in = S_CHECK;
            end else begin
               pos_in = entry_count_ff[IDX_W-1:0];
               if (entry_count_ff != '0) begin
                  rd_addr  = entry_count_ff[IDX_W-1:0] - IDX_W'(1);
                  state_in = S_SHIFT;
               end else begin
                  state_in = S_PLACE;
               end
            end
         end
         S_SHIFT: begin
            // rd_data holds the entry just below pos
            if (rd_data.exp < exp_ff) begin
               wr_en   = 1'b1;
               wr_addr = pos_ff;
               wr_data = rd_data;
               pos_in  = pos_ff - IDX_W'(1);
               if (pos_ff != IDX_W'(1)) begin
                  rd_addr = pos_ff - IDX_W'(1) - IDX_W'(1);
               end else begin
                  state_in = S_PLACE;
               end
            end else begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            wr_en          = 1'b1;
            wr_addr        = pos_ff;
            wr_data.tag    = tag_ff;
            wr_data.exp    = exp_ff;
            entry_count_in = entry_count_ff + CNT_W'(1);
            size_sum_in    = size_sum_ff + (SUM_W'(1) << exp_ff);
            state_in       = S_CHECK;
         end
         S_CHECK: begin
            if (error_code_ff == ST_OK && size_sum_ff > SUM_W'(base_cfg.total)) begin
               err_final = ST_NO_SPACE;
            end
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (err_final != ST_OK || entry_count_ff == '0) begin
               rsp_in.result_tag    = '0;
               rsp_in.block_size    = '0;
               rsp_in.start_address = '0;
               rsp_in.subnet_prefix = '0;
               rsp_in.status        = err_final;
               rsp_in.last_result   = 1'b1;
               rsp_strobe_in        = 1'b1;
               entry_count_in       = '0;
               size_sum_in          = '0;
               error_code_in        = ST_OK;
               state_in             = S_IDLE;
            end else begin
               cur_in   = base_cfg.order_down
                        ? ({1'b0, base_cfg.network} + base_cfg.total)
                        : {1'b0, base_cfg.network};
               k_in     = '0;
               rd_addr  = '0;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (base_cfg.order_down) begin
               cur_next = cur_ff - step_size;
               rsp_in.start_address = cur_next[ADDR_W-1:0];
            end else begin
               cur_next = cur_ff + step_size;
               rsp_in.start_address = cur_ff[ADDR_W-1:0];
            end
            cur_in               = cur_next;
            rsp_in.result_tag    = rd_data.tag;
            rsp_in.block_size    = ADDR_W'(1) << rd_data.exp;
            rsp_in.subnet_prefix = PFX_W'(ADDR_W) - PFX_W'(rd_data.exp);
            rsp_in.status        = ST_OK;
            rsp_in.last_result   = (CNT_W'(k_ff) + CNT_W'(1) == entry_count_ff);
            rsp_strobe_in        = 1'b1;
            if (rsp_in.last_result) begin
               entry_count_in = '0;
               size_sum_in    = '0;
               error_code_in  = ST_OK;
               state_in       = S_IDLE;
            end else begin
               k_in    = k_ff + IDX_W'(1);
               rd_addr = k_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         entry_count_ff <= '0;
         size_sum_ff    <= '0;
         error_code_ff  <= ST_OK;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         size_sum_ff    <= size_sum_in;
         error_code_ff  <= error_code_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff   <= tag_in;
      count_ff <= count_in;
      last_ff  <= last_in;
      exp_ff   <= exp_in;
      pos_ff   <= pos_in;
      k_ff     <= k_in;
      cur_ff   <= cur_in;
      rsp_ff   <= rsp_in;
   end

endmodule
